// File: rtl/core/flp_pkg.sv
`default_nettype none
package flp_pkg;

    localparam int LFSR_BITS = 32;
    localparam logic [63:0] LFSR_TAPS_64 = 64'h0000_0000_8020_0003;
    localparam logic [LFSR_BITS-1:0] LFSR_TAPS = LFSR_TAPS_64[LFSR_BITS-1:0];

    localparam logic [8:0]  RST_SAT_GAIN  = 9'd282;
    localparam logic [8:0]  RST_RED_GAIN  = 9'd264;
    localparam logic [8:0]  RST_BLUE_GAIN = 9'd248;
    localparam logic [15:0] RST_GRAIN_AMP = 16'd522;
    localparam logic [31:0] RST_GRAIN_SEED = 32'd1;

    localparam logic [2:0] REG_SAT_GAIN   = 3'd0;
    localparam logic [2:0] REG_RED_GAIN   = 3'd1;
    localparam logic [2:0] REG_BLUE_GAIN  = 3'd2;
    localparam logic [2:0] REG_GRAIN_AMP  = 3'd3;
    localparam logic [2:0] REG_GRAIN_SEED = 3'd4;

    typedef logic [7:0] t_rom [256];

    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_GAIN,
        SAT_DIV
    } t_sat_mode;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SAT,
        B_GAIN,
        B_OUT
    } t_back_state;

    typedef struct packed {
        logic [2:0][7:0] ch;
        logic [8:0]      s;
        logic [7:0]      d;
        logic [7:0]      den;
        t_sat_mode       mode;
        logic            eof;
        logic [15:0]     u;
    } t_job;

    typedef struct packed {
        logic [8:0]  red_gain;
        logic [8:0]  blue_gain;
        logic [8:0]  sat_gain;
        logic [15:0] grain_amp;
    } t_cfg;

    function automatic logic [191:0] pow_big(input logic [191:0] b, input int e);
        logic [191:0] p;
        p = 192'd1;
        for (int i = 0; i < e; i++) begin
            p = p * b;
        end
        return p;
    endfunction

    // largest v with v^23 <= min(x,242)^20 * 255^3
    function automatic t_rom build_tone();
        t_rom rom;
        logic [191:0] target;
        int v;
        int y;
        v = 0;
        for (int x = 0; x < 256; x++) begin
            y = (x > 242) ? 242 : x;
            target = pow_big(192'(y), 20) * pow_big(192'd255, 3);
            for (int k = 0; k < 256; k++) begin
                if (v < 255 && pow_big(192'(v + 1), 23) <= target) begin
                    v = v + 1;
                end
            end
            rom[x] = 8'(v);
        end
        return rom;
    endfunction

    // fade toward gray, then bloom above the highlight knee
    function automatic t_rom build_fade();
        t_rom rom;
        int v;
        for (int x = 0; x < 256; x++) begin
            v = (194 * x + 765) / 200;
            if (v >= 205) begin
                v = (7 * v - 408) / 5;
                if (v > 255) begin
                    v = 255;
                end
            end
            rom[x] = 8'(v);
        end
        return rom;
    endfunction

    localparam t_rom TONE_ROM = build_tone();
    localparam t_rom FADE_ROM = build_fade();

    function automatic logic [LFSR_BITS-1:0] seed_load(input logic [31:0] seed);
        logic [63:0] wide;
        logic [LFSR_BITS-1:0] v;
        wide = 64'(seed);
        v = wide[LFSR_BITS-1:0];
        if (v == '0) begin
            v = LFSR_BITS'(1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/flp_front.sv
`default_nettype none
module flp_front import flp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic        i_eof,
    input  wire logic [8:0]  i_sat_gain,
    input  wire logic [31:0] i_seed,
    output t_job             o_job
);

    logic [LFSR_BITS-1:0] r_lfsr;
    logic [LFSR_BITS-1:0] n_lfsr;
    logic [7:0] c0, c1, c2, mx, mn;
    logic [8:0] s;
    logic [7:0] d;
    logic [7:0] den;
    logic [16:0] gd;
    logic [16:0] lim;

    always_comb begin
        c0 = TONE_ROM[i_red];
        c1 = TONE_ROM[i_green];
        c2 = TONE_ROM[i_blue];
        mx = c0;
        mn = c0;
        if (c1 > mx) mx = c1;
        if (c2 > mx) mx = c2;
        if (c1 < mn) mn = c1;
        if (c2 < mn) mn = c2;
        s   = {1'b0, mx} + {1'b0, mn};
        d   = mx - mn;
        den = (s > 9'd255) ? 8'(9'd510 - s) : s[7:0];
        gd  = 17'(i_sat_gain) * 17'(d);
        lim = {1'b0, den, 8'd0};

        o_job.ch  = {c2, c1, c0};
        o_job.s   = s;
        o_job.d   = d;
        o_job.den = den;
        o_job.eof = i_eof;
        o_job.u   = r_lfsr[15:0];
        if (d == 8'd0) begin
            o_job.mode = SAT_NONE;
        end else if (gd <= lim) begin
            o_job.mode = SAT_GAIN;
        end else begin
            o_job.mode = SAT_DIV;
        end

        n_lfsr = r_lfsr >> 1;
        if (r_lfsr[0]) begin
            n_lfsr = n_lfsr ^ LFSR_TAPS;
        end
        if (i_eof) begin
            n_lfsr = seed_load(i_seed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= seed_load(RST_GRAIN_SEED);
        end else if (i_accept) begin
            r_lfsr <= n_lfsr;
        end
    end

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0) else $error("grain lfsr reached zero");
    a_lfsr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_lfsr)) else $error("lfsr moved without an item");
    a_gray_mode: assert property (@(posedge i_clk)
        (d == 8'd0) |-> (o_job.mode == SAT_NONE)) else $error("gray pixel not bypassed");

endmodule
`default_nettype wire

// File: rtl/core/flp_queue.sv
`default_nettype none
module flp_queue import flp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_data
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wr != r_rd)) else $error("queue pointers out of step");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count missed a push");

endmodule
`default_nettype wire

// File: rtl/core/flp_back.sv
`default_nettype none
module flp_back import flp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cfg            i_cfg,
    input  wire logic       i_q_empty,
    input  t_job            i_q_data,
    output logic            o_q_pop,
    output logic            o_valid,
    input  wire logic       i_pop,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic            o_eof
);

    t_back_state     r_state, n_state;
    t_job            r_job, n_job;
    logic [2:0][7:0] r_c, n_c;
    logic [1:0]      r_ch, n_ch;
    logic            r_busy, n_busy;
    logic [2:0]      r_bit, n_bit;
    logic [18:0]     r_rem, n_rem;
    logic [7:0]      r_q, n_q;
    logic signed [9:0] r_delta, n_delta;
    logic            r_valid, n_valid;
    logic [7:0]      r_red, n_red, r_green, n_green, r_blue, n_blue;
    logic            r_eof, n_eof;

    logic [7:0]         x;
    logic signed [10:0] t;
    logic signed [20:0] n1;
    logic signed [20:0] n2;
    logic [8:0]         dv;
    logic [16:0]        dv_top;
    logic [16:0]        trial;
    logic [7:0]         chan_res;
    logic               chan_done;
    logic [16:0]        pr, pb;
    logic signed [16:0] uc;
    logic signed [33:0] gp;
    logic signed [10:0] sum [3];
    logic [7:0]         fb [3];

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_eof   = r_eof;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_c     = r_c;
        n_ch    = r_ch;
        n_busy  = r_busy;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_q     = r_q;
        n_delta = r_delta;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        n_eof   = r_eof;
        n_valid = r_valid && !i_pop;
        o_q_pop = 1'b0;

        x      = r_job.ch[r_ch];
        t      = $signed({2'b00, x, 1'b0}) - $signed({2'b00, r_job.s});
        n1     = $signed({4'd0, r_job.s, 8'd0}) + 21'(t * $signed({1'b0, i_cfg.sat_gain}));
        n2     = $signed(21'({r_job.s} * {r_job.d}))
                 + 21'(t * $signed({1'b0, r_job.den}));
        dv     = {r_job.d, 1'b0};
        dv_top = {dv, 8'd0};
        trial  = 17'(dv) << r_bit;
        chan_res  = 8'd0;
        chan_done = 1'b0;

        pr = 17'(r_c[0]) * 17'(i_cfg.red_gain);
        pb = 17'(r_c[2]) * 17'(i_cfg.blue_gain);
        uc = $signed({1'b0, r_job.u}) - 17'sd32768;
        gp = 34'(uc) * $signed({18'd0, i_cfg.grain_amp});
        for (int i = 0; i < 3; i++) begin
            fb[i]  = FADE_ROM[r_c[i]];
            sum[i] = $signed({3'b000, fb[i]}) + 11'(r_delta);
        end

        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_data;
                    n_c     = i_q_data.ch;
                    n_ch    = 2'd0;
                    n_busy  = 1'b0;
                    n_state = (i_q_data.mode == SAT_NONE) ? B_GAIN : B_SAT;
                end
            end
            B_SAT: begin
                if (r_job.mode == SAT_GAIN) begin
                    chan_done = 1'b1;
                    if (n1 < 0) begin
                        chan_res = 8'd0;
                    end else if (n1[20:9] > 12'd255) begin
                        chan_res = 8'd255;
                    end else begin
                        chan_res = n1[16:9];
                    end
                end else if (!r_busy) begin
                    if (n2 < 0) begin
                        chan_done = 1'b1;
                        chan_res  = 8'd0;
                    end else if (n2[18:0] >= 19'(dv_top)) begin
                        chan_done = 1'b1;
                        chan_res  = 8'd255;
                    end else begin
                        // start restoring division, one quotient bit a cycle
                        n_busy = 1'b1;
                        n_rem  = n2[18:0];
                        n_q    = 8'd0;
                        n_bit  = 3'd7;
                    end
                end else begin
                    chan_res = r_q;
                    if (r_rem >= 19'(trial)) begin
                        n_rem    = r_rem - 19'(trial);
                        chan_res = r_q | (8'd1 << r_bit);
                    end
                    n_q   = chan_res;
                    n_bit = r_bit - 3'd1;
                    if (r_bit == 3'd0) begin
                        chan_done = 1'b1;
                        n_busy    = 1'b0;
                    end
                end
                if (chan_done) begin
                    n_c[r_ch] = chan_res;
                    if (r_ch == 2'd2) begin
                        n_state = B_GAIN;
                    end else begin
                        n_ch = r_ch + 2'd1;
                    end
                end
            end
            B_GAIN: begin
                n_c[0]  = (pr[16:8] > 9'd255) ? 8'd255 : pr[15:8];
                n_c[2]  = (pb[16:8] > 9'd255) ? 8'd255 : pb[15:8];
                n_delta = gp[32:23];
                n_state = B_OUT;
            end
            B_OUT: begin
                if (!r_valid) begin
                    n_red   = (sum[0] < 0) ? 8'd0 : ((sum[0] > 11'sd255) ? 8'd255 : sum[0][7:0]);
                    n_green = (sum[1] < 0) ? 8'd0 : ((sum[1] > 11'sd255) ? 8'd255 : sum[1][7:0]);
                    n_blue  = (sum[2] < 0) ? 8'd0 : ((sum[2] > 11'sd255) ? 8'd255 : sum[2][7:0]);
                    n_eof   = r_job.eof;
                    n_valid = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_ch    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_busy  <= n_busy;
            r_ch    <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_c     <= n_c;
        r_bit   <= n_bit;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_delta <= n_delta;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_eof   <= n_eof;
    end

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SAT) |-> (r_ch <= 2'd2)) else $error("channel index out of range");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SAT && r_busy) |-> (r_rem < (19'(dv) << (r_bit + 4'd1))))
        else $error("division remainder too large");
    a_busy_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_state == B_SAT && r_job.mode == SAT_DIV))
        else $error("divider busy outside division");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_red) && $stable(r_blue)))
        else $error("waiting result changed");

endmodule
`default_nettype wire

// File: rtl/core/film_look_rgb_pixel_pipeline.sv
// Sequencing: a gray pixel skips saturation; plain gain saturation takes one channel
//   a cycle; for division saturation a channel may run through the shared 8-step divider,
//   one quotient bit a cycle. The back-end sequencer finishes one pixel before taking
//   the next, and holds in its output state while the result slot is still full.
// Reset: synchronous, active low; registers return to defaults, the grain
//   LFSR loads the default seed, queue and result slot are emptied.
`default_nettype none
module film_look_rgb_pixel_pipeline import flp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel input queue
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic        i_end_of_frame,
    // result slot
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic             o_frame_done,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [8:0]  r_sat_gain;
    logic [8:0]  r_red_gain;
    logic [8:0]  r_blue_gain;
    logic [15:0] r_grain_amp;
    logic [31:0] r_grain_seed;
    logic [2:0]  reg_idx;
    logic        wr_en;

    t_cfg cfg;
    t_job front_job;
    t_job q_job;
    logic accept;
    logic q_empty;
    logic q_pop;
    logic out_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // write a register at the access phase; unknown addresses drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_gain   <= RST_SAT_GAIN;
            r_red_gain   <= RST_RED_GAIN;
            r_blue_gain  <= RST_BLUE_GAIN;
            r_grain_amp  <= RST_GRAIN_AMP;
            r_grain_seed <= RST_GRAIN_SEED;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SAT_GAIN:   r_sat_gain   <= pwdata[8:0];
                REG_RED_GAIN:   r_red_gain   <= pwdata[8:0];
                REG_BLUE_GAIN:  r_blue_gain  <= pwdata[8:0];
                REG_GRAIN_AMP:  r_grain_amp  <= pwdata[15:0];
                REG_GRAIN_SEED: r_grain_seed <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SAT_GAIN:   prdata = 32'(r_sat_gain);
            REG_RED_GAIN:   prdata = 32'(r_red_gain);
            REG_BLUE_GAIN:  prdata = 32'(r_blue_gain);
            REG_GRAIN_AMP:  prdata = 32'(r_grain_amp);
            REG_GRAIN_SEED: prdata = r_grain_seed;
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.sat_gain  = r_sat_gain;
    assign cfg.red_gain  = r_red_gain;
    assign cfg.blue_gain = r_blue_gain;
    assign cfg.grain_amp = r_grain_amp;

    // front end: tone curve, classify saturation, draw grain, advance LFSR (reseed at end of frame)
    assign accept = push && !full;

    flp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_red      (i_red_in),
        .i_green    (i_green_in),
        .i_blue     (i_blue_in),
        .i_eof      (i_end_of_frame),
        .i_sat_gain (r_sat_gain),
        .i_seed     (r_grain_seed),
        .o_job      (front_job)
    );

    // two-entry queue decouples the front end from the back-end sequencer
    flp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    // back end: saturation, color cast, fade/bloom, grain; holds the result
    flp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_job),
        .o_q_pop   (q_pop),
        .o_valid   (out_valid),
        .i_pop     (pop),
        .o_red     (o_red_out),
        .o_green   (o_green_out),
        .o_blue    (o_blue_out),
        .o_eof     (o_frame_done)
    );

    assign empty = !out_valid;

endmodule
`default_nettype wire
